// ===== rtl/core/ldg_pkg.sv =====
package ldg_pkg;

    // Field and datapath widths
    localparam int COUNTER_BITS = 32;
    localparam int MAX_LEVELS   = 16;
    localparam int LEVEL_W      = 4;
    localparam int PCT_W        = 7;
    localparam int WEIGHT_W     = 8;
    localparam int NLEV_W       = 5;
    localparam int NUM_W        = COUNTER_BITS + 7;   // busy * 100 fits here
    localparam int QUOT_W       = 11;                 // largest quotient is the level step
    localparam int DIV_CNT_W    = $clog2(QUOT_W);
    localparam int LVL_CALC_W   = QUOT_W + 2;

    // Stream data widths, padded to whole bytes
    localparam int S_FIELDS_W = 2 * COUNTER_BITS + LEVEL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = LEVEL_W + 1 + 2 * PCT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS  = 2'd3;

    localparam logic [PCT_W-1:0]    RST_LOAD_TARGET = 7'd70;
    localparam logic [PCT_W-1:0]    RST_LOAD_MAX    = 7'd90;
    localparam logic [WEIGHT_W-1:0] RST_SMOOTHING   = 8'd1;
    localparam logic [NLEV_W-1:0]   RST_NUM_LEVELS  = NLEV_W'(MAX_LEVELS);

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic start_util;
        logic take_util;
        logic start_avg;
        logic take_avg;
        logic start_step;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_sts;

    // One result item
    typedef struct packed {
        logic [PCT_W-1:0]   average_load;
        logic [PCT_W-1:0]   utilization;
        logic               level_changed;
        logic [LEVEL_W-1:0] new_level;
    } t_res;

    // n / 3 for small n by reciprocal multiply (exact for n below 512)
    function automatic logic [NLEV_W-1:0] third_of(input logic [NLEV_W-1:0] n);
        logic [NLEV_W+8:0] p;
        p = (NLEV_W + 9)'(n) * (NLEV_W + 9)'(171);
        return p[NLEV_W+8:9];
    endfunction

endpackage

// ===== rtl/core/load_based_dvfs_governor.sv =====
// Each item makes three passes through one shared 11-step restoring divider
// (utilization, average, level step); a new input is taken only once the last
// result has been loaded into the output register.
// The next input is taken while a result still waits in the output register.
// Reset (synchronous, active low): controller idle, output empty, running average 0,
// registers at target 70, max 90, smoothing 1, levels 16.
module load_based_dvfs_governor
    import ldg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // busy_cycles, total_cycles, current_level
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata    // new_level, level_changed, utilization,
                                                  // average_load
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_res w_res;

    ldg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ldg_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_busy     (s_axis_tdata[COUNTER_BITS-1:0]),
        .i_total    (s_axis_tdata[2*COUNTER_BITS-1:COUNTER_BITS]),
        .i_cur      (s_axis_tdata[S_FIELDS_W-1:2*COUNTER_BITS]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (w_res)
    );

    // Pack result fields, zero pad to bytes
    assign m_axis_tdata = M_DATA_W'(w_res);

endmodule

// ===== rtl/core/ldg_div.sv =====
module ldg_div
    import ldg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [COUNTER_BITS-1:0] i_den,
    output logic [QUOT_W-1:0]       o_quot,
    output logic                    o_done
);

    localparam int TRIAL_W = COUNTER_BITS + QUOT_W;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]        r_rem;
    logic [COUNTER_BITS-1:0] r_den;
    logic [QUOT_W-1:0]       r_quot;

    logic [TRIAL_W-1:0] w_shift;
    logic [TRIAL_W-1:0] w_diff;
    logic               w_ge;

    // Trial subtract of the divisor shifted to the current quotient bit
    assign w_shift = TRIAL_W'(r_den) << r_cnt;
    assign w_diff  = TRIAL_W'(r_rem) - w_shift;
    assign w_ge    = TRIAL_W'(r_rem) >= w_shift;

    // Sequence one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[NUM_W-1:0];
            end
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");

endmodule

// ===== rtl/core/ldg_dpath.sv =====
module ldg_dpath
    import ldg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [COUNTER_BITS-1:0] i_busy,
    input  logic [COUNTER_BITS-1:0] i_total,
    input  logic [LEVEL_W-1:0]      i_cur,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output t_res                    o_res
);

    // Configuration and running average
    logic [PCT_W-1:0]    r_target;
    logic [PCT_W-1:0]    r_max;
    logic [WEIGHT_W-1:0] r_weight;
    logic [NLEV_W-1:0]   r_nlev;
    logic [PCT_W-1:0]    r_avg;

    // Per-item working registers
    logic [COUNTER_BITS-1:0] r_total;
    logic [LEVEL_W-1:0]      r_cur;
    logic [NUM_W-1:0]        r_num;
    logic                    r_uzero;
    logic                    r_usat;
    logic [PCT_W-1:0]        r_util;
    logic                    r_neg;
    logic                    r_jump;
    t_res                    r_res;

    logic                    w_div_start;
    logic [NUM_W-1:0]        w_div_num;
    logic [COUNTER_BITS-1:0] w_div_den;
    logic [QUOT_W-1:0]       w_quot;
    logic                    w_div_done;

    logic [NUM_W-1:0]          w_busy100;
    logic [PCT_W-1:0]          w_target_eff;
    logic [NLEV_W-1:0]         w_nlev_eff;
    logic [2*WEIGHT_W-1:0]     w_avg_num;
    logic [WEIGHT_W:0]         w_avg_den;
    logic signed [PCT_W:0]     w_diff;
    logic [PCT_W:0]            w_mag_full;
    logic [PCT_W-1:0]          w_mag;
    logic [QUOT_W-1:0]         w_mag10;
    logic signed [LVL_CALC_W-1:0] w_cur_s;
    logic signed [LVL_CALC_W-1:0] w_step_s;
    logic signed [LVL_CALC_W-1:0] w_third_s;
    logic signed [LVL_CALC_W-1:0] w_top_s;
    logic signed [LVL_CALC_W-1:0] w_lvl;
    logic [NLEV_W-1:0]         w_top;
    logic [LEVEL_W-1:0]        w_new_level;
    logic [PCT_W-1:0]          w_util_next;
    logic [PCT_W-1:0]          w_avg_next;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_LOAD_TARGET;
            r_max    <= RST_LOAD_MAX;
            r_weight <= RST_SMOOTHING;
            r_nlev   <= RST_NUM_LEVELS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOAD_TARGET: r_target <= i_cfg_data[PCT_W-1:0];
                CFG_LOAD_MAX:    r_max    <= i_cfg_data[PCT_W-1:0];
                CFG_SMOOTHING:   r_weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_NUM_LEVELS:  r_nlev   <= i_cfg_data[NLEV_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective target and level count
    assign w_target_eff = (r_target == '0) ? PCT_W'(1) : r_target;
    always_comb begin
        if (r_nlev == '0) begin
            w_nlev_eff = NLEV_W'(1);
        end else if (r_nlev > NLEV_W'(MAX_LEVELS)) begin
            w_nlev_eff = NLEV_W'(MAX_LEVELS);
        end else begin
            w_nlev_eff = r_nlev;
        end
    end

    // busy * 100 as shifted adds
    assign w_busy100 = NUM_W'({i_busy, 6'b0}) + NUM_W'({i_busy, 5'b0})
                     + NUM_W'({i_busy, 2'b0});

    // Average numerator and denominator
    assign w_avg_num = (2*WEIGHT_W)'(r_weight) * (2*WEIGHT_W)'(r_avg)
                     + (2*WEIGHT_W)'(r_util);
    assign w_avg_den = (WEIGHT_W+1)'(r_weight) + 1'b1;

    // Magnitude of (avg - target) * 10
    assign w_diff     = $signed({1'b0, r_avg}) - $signed({1'b0, w_target_eff});
    assign w_mag_full = w_diff[PCT_W] ? (PCT_W+1)'(-w_diff) : (PCT_W+1)'(w_diff);
    assign w_mag      = w_mag_full[PCT_W-1:0];
    assign w_mag10    = QUOT_W'({w_mag, 3'b0}) + QUOT_W'({w_mag, 1'b0});

    // Select divider operands
    assign w_div_start = i_cmd.start_util | i_cmd.start_avg | i_cmd.start_step;
    always_comb begin
        w_div_num = r_num;
        w_div_den = r_total;
        if (i_cmd.start_avg) begin
            w_div_num = NUM_W'(w_avg_num);
            w_div_den = COUNTER_BITS'(w_avg_den);
        end else if (i_cmd.start_step) begin
            w_div_num = NUM_W'(w_mag10);
            w_div_den = COUNTER_BITS'(w_target_eff);
        end
    end

    ldg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    assign o_sts.div_done = w_div_done;

    // Saturate quotients to percent
    always_comb begin
        if (r_uzero) begin
            w_util_next = '0;
        end else if (r_usat || (w_quot > QUOT_W'(PCT_FULL))) begin
            w_util_next = PCT_FULL;
        end else begin
            w_util_next = w_quot[PCT_W-1:0];
        end
        w_avg_next = (w_quot > QUOT_W'(PCT_FULL)) ? PCT_FULL : w_quot[PCT_W-1:0];
    end

    // Next level: jump, or signed step halved toward zero, then clamp
    assign w_cur_s   = $signed(LVL_CALC_W'(r_cur));
    assign w_step_s  = $signed(LVL_CALC_W'(w_quot[QUOT_W-1:1]));
    assign w_third_s = $signed(LVL_CALC_W'(third_of(w_nlev_eff)));
    assign w_top     = w_nlev_eff - 1'b1;
    assign w_top_s   = $signed(LVL_CALC_W'(w_top));
    always_comb begin
        if (r_jump) begin
            w_lvl = w_cur_s + w_third_s;
        end else if (r_neg) begin
            w_lvl = w_cur_s - w_step_s;
        end else begin
            w_lvl = w_cur_s + w_step_s;
        end
        if (w_lvl < 0) begin
            w_new_level = '0;
        end else if (w_lvl > w_top_s) begin
            w_new_level = w_top[LEVEL_W-1:0];
        end else begin
            w_new_level = w_lvl[LEVEL_W-1:0];
        end
    end

    // Running average state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_cmd.take_avg) begin
            r_avg <= w_avg_next;
        end
    end

    // Per-item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_total <= i_total;
            r_cur   <= i_cur;
            r_num   <= w_busy100;
        end
        if (i_cmd.start_util) begin
            r_uzero <= (r_total == '0);
            r_usat  <= (r_num >= {r_total, 7'b0});
        end
        if (i_cmd.take_util) begin
            r_util <= w_util_next;
        end
        if (i_cmd.start_step) begin
            r_neg  <= w_diff[PCT_W];
            r_jump <= (r_avg > r_max);
        end
        if (i_cmd.load_out) begin
            r_res.new_level     <= w_new_level;
            r_res.level_changed <= (w_new_level != r_cur);
            r_res.utilization   <= r_util;
            r_res.average_load  <= r_avg;
        end
    end

    assign o_res = r_res;

    a_avg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg <= PCT_FULL)
        else $error("running average above full load");

endmodule

// ===== rtl/core/ldg_ctrl.sv =====
module ldg_ctrl
    import ldg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UDIV  = 3'd1;
    localparam logic [2:0] S_UWAIT = 3'd2;
    localparam logic [2:0] S_ADIV  = 3'd3;
    localparam logic [2:0] S_AWAIT = 3'd4;
    localparam logic [2:0] S_SDIV  = 3'd5;
    localparam logic [2:0] S_SWAIT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       w_cmd;

    // Sequence utilization, average and step divisions
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_UDIV;
                end
            end
            S_UDIV: begin
                w_cmd.start_util = 1'b1;
                n_state          = S_UWAIT;
            end
            S_UWAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.take_util = 1'b1;
                    n_state         = S_ADIV;
                end
            end
            S_ADIV: begin
                w_cmd.start_avg = 1'b1;
                n_state         = S_AWAIT;
            end
            S_AWAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.take_avg = 1'b1;
                    n_state        = S_SDIV;
                end
            end
            S_SDIV: begin
                w_cmd.start_step = 1'b1;
                n_state          = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until the output transfer completes
    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before transfer");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_UWAIT || r_state == S_AWAIT
                            || r_state == S_SWAIT))
        else $error("divider finished outside a wait state");

endmodule
